>>> design/ttgm_pkg.sv
// ----------------------------------------------------------------------------
// ttgm_pkg
// Shared types and constants of the transcript to genome mapper.
// ----------------------------------------------------------------------------
package ttgm_pkg;

    localparam int MAX_EXONS_DEF  = 32;
    localparam int COORD_BITS_DEF = 31;
    localparam int IN_W           = 31;
    localparam int LEN_W          = 31;
    localparam int GEN_W          = 32;
    localparam int CMD_W          = 32;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_MAP    = 2'd2
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [CMD_W-1:0] v0;
        logic [CMD_W-1:0] v1;
        logic             fwd;
    } t_cmd;

    typedef struct packed {
        logic             intron;
        logic [LEN_W-1:0] len;
        logic [GEN_W-1:0] gb;
        logic [GEN_W-1:0] ge;
        logic             fwd;
        logic             none;
        logic             ovf;
        logic             last;
    } t_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_INTRON,
        ST_LAST
    } t_bstate;

endpackage

>>> design/ttgm_fifo.sv
// ----------------------------------------------------------------------------
// ttgm_fifo
// Small register queue, push/full on the write side, pop/empty on the read side.
// ----------------------------------------------------------------------------
module ttgm_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = ttgm_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_rdata
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

>>> design/ttgm_front.sv
// ----------------------------------------------------------------------------
// ttgm_front
// Takes input words, decodes the opcode, orders the read interval and queues
// a command for the back end. Unused opcodes are taken and dropped.
// ----------------------------------------------------------------------------
module ttgm_front #(
    parameter int COORD_BITS = ttgm_pkg::COORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [1:0]                i_opcode,
    input  logic [ttgm_pkg::IN_W-1:0] i_exon_start,
    input  logic [ttgm_pkg::IN_W-1:0] i_exon_stop,
    input  logic [ttgm_pkg::IN_W-1:0] i_read_first,
    input  logic [ttgm_pkg::IN_W-1:0] i_read_second,
    input  logic                      i_transcript_forward,
    output logic                      o_cmd_valid,
    input  logic                      i_cmd_pop,
    output ttgm_pkg::t_cmd            o_cmd
);

    import ttgm_pkg::*;

    localparam int CB = COORD_BITS;

    logic [CB-1:0] rd_a;
    logic [CB-1:0] rd_b;
    logic          rev;
    logic          keep;
    t_cmd          cmd;
    logic          q_empty;
    logic [$bits(t_cmd)-1:0] q_rdata;

    assign rd_a = CB'(i_read_first);
    assign rd_b = CB'(i_read_second);
    assign rev  = (rd_a > rd_b);

    always_comb begin
        cmd  = '0;
        keep = 1'b0;
        unique case (i_opcode)
            OP_CLEAR: begin
                keep   = 1'b1;
                cmd.op = OP_CLEAR;
            end
            OP_APPEND: begin
                keep   = 1'b1;
                cmd.op = OP_APPEND;
                cmd.v0 = CMD_W'(CB'(i_exon_start));
                cmd.v1 = CMD_W'(CB'(i_exon_stop));
            end
            OP_MAP: begin
                keep    = 1'b1;
                cmd.op  = OP_MAP;
                cmd.v0  = CMD_W'(rev ? rd_b : rd_a);
                cmd.v1  = CMD_W'(rev ? rd_a : rd_b);
                cmd.fwd = (!rev) == i_transcript_forward;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    ttgm_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && keep),
        .i_wdata (cmd),
        .o_full  (full),
        .i_pop   (i_cmd_pop),
        .o_empty (q_empty),
        .o_rdata (q_rdata)
    );

    assign o_cmd_valid = !q_empty;
    assign o_cmd       = t_cmd'(q_rdata);

endmodule

>>> design/ttgm_back.sv
// ----------------------------------------------------------------------------
// ttgm_back
// Holds the exon table and carries out commands: clear, append, and the exon
// walk of a map command, one entry per cycle unless stalled, giving runs.
// ----------------------------------------------------------------------------
module ttgm_back #(
    parameter int MAX_EXONS  = ttgm_pkg::MAX_EXONS_DEF,
    parameter int COORD_BITS = ttgm_pkg::COORD_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_pop,
    input  ttgm_pkg::t_cmd i_cmd,
    output logic           o_res_push,
    input  logic           i_res_full,
    output ttgm_pkg::t_res o_res
);

    import ttgm_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int IW = (MAX_EXONS > 1) ? $clog2(MAX_EXONS) : 1;
    localparam int CW = $clog2(MAX_EXONS + 1);
    localparam int OW = CB + $clog2(MAX_EXONS);

    logic [CB-1:0] r_mem_s [MAX_EXONS];
    logic [CB-1:0] r_mem_t [MAX_EXONS];
    logic [CB-1:0] r_rd_s;
    logic [CB-1:0] r_rd_t;

    t_bstate       r_state,     n_state;
    logic [CW-1:0] r_cnt,       n_cnt;
    logic          r_ovf,       n_ovf;
    logic [IW-1:0] r_idx,       n_idx;
    logic          r_walk_end,  n_walk_end;
    logic [CB-1:0] r_pb,        n_pb;
    logic [CB-1:0] r_pe,        n_pe;
    logic          r_gfwd,      n_gfwd;
    logic [OW-1:0] r_tend,      n_tend;
    logic [CB-1:0] r_prev_stop, n_prev_stop;
    logic          r_have_pend, n_have_pend;
    logic          r_pend_intr, n_pend_intr;
    logic [CB-1:0] r_pend_len,  n_pend_len;
    logic [CB-1:0] r_mlen,      n_mlen;
    logic          r_gb_ok,     n_gb_ok;
    logic [CB-1:0] r_gb,        n_gb;
    logic          r_ge_ok,     n_ge_ok;
    logic [CB-1:0] r_ge,        n_ge;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [IW-1:0] rd_addr;

    logic [CB-1:0] elen;
    logic [OW-1:0] tend_n;
    logic [CW-1:0] idx_nxt;
    logic          walk_done;
    logic          brk;
    logic          skip;
    logic          beg_hit;
    logic          end_hit;
    logic [CB-1:0] off_b;
    logic [CB-1:0] off_e;
    logic [CB-1:0] mlen;
    logic [CB-1:0] ilen;
    t_res          pend_res;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_s[wr_addr] <= CB'(i_cmd.v0);
            r_mem_t[wr_addr] <= CB'(i_cmd.v1);
        end
        r_rd_s <= r_mem_s[rd_addr];
        r_rd_t <= r_mem_t[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_walk_end  <= n_walk_end;
        r_pb        <= n_pb;
        r_pe        <= n_pe;
        r_gfwd      <= n_gfwd;
        r_tend      <= n_tend;
        r_prev_stop <= n_prev_stop;
        r_have_pend <= n_have_pend;
        r_pend_intr <= n_pend_intr;
        r_pend_len  <= n_pend_len;
        r_mlen      <= n_mlen;
        r_gb_ok     <= n_gb_ok;
        r_gb        <= n_gb;
        r_ge_ok     <= n_ge_ok;
        r_ge        <= n_ge;
    end

    // per-entry arithmetic of the walk
    always_comb begin
        elen      = (r_rd_t >= r_rd_s) ? r_rd_t - r_rd_s : '0;
        tend_n    = r_tend + OW'(elen);
        idx_nxt   = CW'(r_idx) + CW'(1);
        walk_done = (idx_nxt == r_cnt);
        brk       = (OW'(r_pe) <= r_tend);
        skip      = (tend_n <= OW'(r_pb));
        beg_hit   = (r_tend <= OW'(r_pb));
        end_hit   = (OW'(r_pe) <= tend_n);
        off_b     = beg_hit ? CB'(OW'(r_pb) - r_tend) : '0;
        off_e     = end_hit ? CB'(OW'(r_pe) - r_tend) : elen;
        mlen      = (off_e >= off_b) ? off_e - off_b : '0;
        ilen      = (r_rd_s >= r_prev_stop) ? r_rd_s - r_prev_stop : '0;

        pend_res        = '0;
        pend_res.intron = r_pend_intr;
        pend_res.len    = LEN_W'(r_pend_len);
        pend_res.fwd    = r_gfwd;
        pend_res.ovf    = r_ovf;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_ovf       = r_ovf;
        n_idx       = r_idx;
        n_walk_end  = r_walk_end;
        n_pb        = r_pb;
        n_pe        = r_pe;
        n_gfwd      = r_gfwd;
        n_tend      = r_tend;
        n_prev_stop = r_prev_stop;
        n_have_pend = r_have_pend;
        n_pend_intr = r_pend_intr;
        n_pend_len  = r_pend_len;
        n_mlen      = r_mlen;
        n_gb_ok     = r_gb_ok;
        n_gb        = r_gb;
        n_ge_ok     = r_ge_ok;
        n_ge        = r_ge;
        o_cmd_pop   = 1'b0;
        o_res_push  = 1'b0;
        o_res       = pend_res;
        wr_en       = 1'b0;
        wr_addr     = r_cnt[IW-1:0];
        rd_addr     = r_idx;

        unique case (r_state)
            ST_IDLE: begin
                rd_addr = '0;
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.op)
                        OP_CLEAR: begin
                            n_cnt = '0;
                            n_ovf = 1'b0;
                        end
                        OP_APPEND: begin
                            if (r_cnt < CW'(MAX_EXONS)) begin
                                wr_en = 1'b1;
                                n_cnt = r_cnt + CW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        OP_MAP: begin
                            n_pb        = CB'(i_cmd.v0);
                            n_pe        = CB'(i_cmd.v1);
                            n_gfwd      = i_cmd.fwd;
                            n_idx       = '0;
                            n_walk_end  = 1'b0;
                            n_tend      = '0;
                            n_have_pend = 1'b0;
                            n_gb_ok     = 1'b0;
                            n_ge_ok     = 1'b0;
                            n_state     = (r_cnt == '0) ? ST_LAST : ST_WALK;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (brk) begin
                    n_state = ST_LAST;
                end else if (skip || !r_have_pend || !i_res_full) begin
                    n_prev_stop = r_rd_t;
                    n_tend      = tend_n;
                    n_walk_end  = walk_done;
                    if (!walk_done) begin
                        n_idx   = IW'(idx_nxt);
                        rd_addr = IW'(idx_nxt);
                    end
                    n_state = walk_done ? ST_LAST : ST_WALK;
                    if (!skip) begin
                        if (beg_hit) begin
                            n_gb_ok = 1'b1;
                            n_gb    = r_rd_s + off_b;
                        end
                        if (end_hit) begin
                            n_ge_ok = 1'b1;
                            n_ge    = r_rd_s + off_e;
                        end
                        if (r_have_pend) begin
                            // two runs from this exon: the intron goes out from ST_INTRON
                            o_res_push  = 1'b1;
                            n_pend_intr = 1'b1;
                            n_pend_len  = ilen;
                            n_mlen      = mlen;
                            n_state     = ST_INTRON;
                        end else begin
                            n_have_pend = 1'b1;
                            n_pend_intr = 1'b0;
                            n_pend_len  = mlen;
                        end
                    end
                end
            end
            ST_INTRON: begin
                if (!i_res_full) begin
                    o_res_push  = 1'b1;
                    n_pend_intr = 1'b0;
                    n_pend_len  = r_mlen;
                    n_state     = r_walk_end ? ST_LAST : ST_WALK;
                end
            end
            ST_LAST: begin
                o_res.last = 1'b1;
                if (r_have_pend) begin
                    o_res.gb = r_gb_ok ? GEN_W'(r_gb) : '1;
                    o_res.ge = r_ge_ok ? GEN_W'(r_ge) : '1;
                end else begin
                    o_res.intron = 1'b0;
                    o_res.len    = '0;
                    o_res.gb     = '1;
                    o_res.ge     = '1;
                    o_res.none   = 1'b1;
                end
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/transcript_to_genome_mapper.sv
// ----------------------------------------------------------------------------
// transcript_to_genome_mapper
// Maps a read interval in transcript coordinates onto the genome through a
// table of up to MAX_EXONS exons. Clear and append words are carried out by
// the back end and give no result. A map word is dispatched from idle, walks
// the exon table one entry at a time (the table has one registered read
// port), passes through an extra state for each intron run, and ends with
// the final run. Results come out oldest first; the last run of a map word
// carries genome begin/end, and every run carries strand and the overflow
// flag. The front end takes a word per cycle while its two-word command
// queue is not full, and results wait in a two-word queue, so either side
// can stall independently. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module transcript_to_genome_mapper #(
    parameter int MAX_EXONS  = ttgm_pkg::MAX_EXONS_DEF,
    parameter int COORD_BITS = ttgm_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [1:0]                        i_opcode,
    input  logic [ttgm_pkg::IN_W-1:0]         i_exon_start,
    input  logic [ttgm_pkg::IN_W-1:0]         i_exon_stop,
    input  logic [ttgm_pkg::IN_W-1:0]         i_read_first,
    input  logic [ttgm_pkg::IN_W-1:0]         i_read_second,
    input  logic                              i_transcript_forward,
    output logic                              empty,
    input  logic                              pop,
    output logic                              o_run_is_intron,
    output logic [ttgm_pkg::LEN_W-1:0]        o_run_length,
    output logic signed [ttgm_pkg::GEN_W-1:0] o_genome_begin,
    output logic signed [ttgm_pkg::GEN_W-1:0] o_genome_end,
    output logic                              o_genome_forward,
    output logic                              o_no_overlap,
    output logic                              o_table_overflowed,
    output logic                              o_last
);

    import ttgm_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;
    logic res_push;
    logic res_full;
    t_res res_in;
    t_res res_out;
    logic [$bits(t_res)-1:0] resq_rdata;

    ttgm_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .push                 (push),
        .full                 (full),
        .i_opcode             (i_opcode),
        .i_exon_start         (i_exon_start),
        .i_exon_stop          (i_exon_stop),
        .i_read_first         (i_read_first),
        .i_read_second        (i_read_second),
        .i_transcript_forward (i_transcript_forward),
        .o_cmd_valid          (cmd_valid),
        .i_cmd_pop            (cmd_pop),
        .o_cmd                (cmd)
    );

    ttgm_back #(
        .MAX_EXONS  (MAX_EXONS),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_cmd       (cmd),
        .o_res_push  (res_push),
        .i_res_full  (res_full),
        .o_res       (res_in)
    );

    ttgm_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (QUEUE_DEPTH)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_rdata (resq_rdata)
    );

    assign res_out            = t_res'(resq_rdata);
    assign o_run_is_intron    = res_out.intron;
    assign o_run_length       = res_out.len;
    assign o_genome_begin     = res_out.gb;
    assign o_genome_end       = res_out.ge;
    assign o_genome_forward   = res_out.fwd;
    assign o_no_overlap       = res_out.none;
    assign o_table_overflowed = res_out.ovf;
    assign o_last             = res_out.last;

endmodule
